@@ rtl/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int unsigned DefBookDepth = 16;

  typedef enum logic [2:0] {
    EV_ACK    = 3'd0,
    EV_FILL   = 3'd1,
    EV_REJECT = 3'd2,
    EV_CANCEL = 3'd3,
    EV_FULL   = 3'd4
  } ev_kind_e;

  // one resting order
  typedef struct packed {
    logic               sell;
    logic signed [31:0] price;
    logic [31:0]        ident;
    logic [31:0]        left;
    logic [31:0]        age;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic fill_rest;
    logic fill_inc;
    logic emit_reject;
    logic free_start;
    logic free_step;
    logic insert;
    logic emit_full;
    logic cancel_hit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_cancel;
    logic in_qty_zero;
    logic scan_done;
    logic found;
    logic is_cancel;
    logic market;
    logic qty_zero;
    logic iter_last;
    logic free_hit;
    logic free_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/lobm_dp.sv @@
// ----------------------------------------------------------------------------
// lobm_dp
// Book storage, scan/compare unit, quantity math and output register.
// ----------------------------------------------------------------------------
module lobm_dp import lobm_pkg::*; #(
  parameter int unsigned BOOK_DEPTH = DefBookDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               action_i,
  input  logic [31:0]        order_ident_i,
  input  logic signed [31:0] limit_price_i,
  input  logic [31:0]        share_count_i,
  input  logic               is_sell_i,
  input  logic               is_market_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_kind_o,
  output logic [31:0]        event_order_o,
  output logic signed [31:0] event_price_o,
  output logic [31:0]        event_shares_o,
  output logic               event_sell_o,
  output logic               last_event_o
);

  localparam int unsigned IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(BOOK_DEPTH - 1);

  entry_t mem_q [BOOK_DEPTH];
  logic [BOOK_DEPTH-1:0] valid_q;
  logic [31:0] arrival_q;

  // latched input word
  logic               cancel_q, sell_q, market_q;
  logic [31:0]        ident_q, qty_q;
  logic signed [31:0] limit_q;

  // scan pipeline
  logic          issue_q, rd_vld_q, rd_valid_q;
  logic [IW-1:0] scan_idx_q, rd_idx_q;
  entry_t        rd_q;

  // best candidate
  logic          found_q;
  logic [IW-1:0] best_idx_q;
  entry_t        best_q;

  logic [CW-1:0] iter_q;
  logic [31:0]   fill_q;
  logic [IW-1:0] free_idx_q;

  // output register
  logic               ov_q, olast_q, osell_q;
  ev_kind_e           okind_q;
  logic [31:0]        oident_q, oshares_q;
  logic signed [31:0] oprice_q;

  logic        cand_ok, low_wins, ahead, take, price_ok;
  logic [31:0] cand_dist, best_dist, fill_amt;
  logic        out_free;

  assign out_free = !ov_q || out_ready_i;
  assign fill_amt = (best_q.left < qty_q) ? best_q.left : qty_q;

  always_comb begin
    price_ok  = market_q || (sell_q ? (rd_q.price >= limit_q) : (rd_q.price <= limit_q));
    cand_ok   = rd_vld_q && rd_valid_q &&
                (cancel_q ? (rd_q.ident == ident_q) : ((rd_q.sell != sell_q) && price_ok));
    low_wins  = cancel_q || !sell_q;
    cand_dist = arrival_q - rd_q.age;
    best_dist = arrival_q - best_q.age;
    if (rd_q.price != best_q.price) begin
      ahead = low_wins ? (rd_q.price < best_q.price) : (rd_q.price > best_q.price);
    end else begin
      ahead = cand_dist > best_dist;
    end
    take = cand_ok && (!found_q || ahead);
  end

  // storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[scan_idx_q];
    if (cmd_i.fill_rest) begin
      mem_q[best_idx_q] <= '{sell: best_q.sell, price: best_q.price, ident: best_q.ident,
                             left: best_q.left - fill_amt, age: best_q.age};
    end else if (cmd_i.insert) begin
      mem_q[free_idx_q] <= '{sell: sell_q, price: limit_q, ident: ident_q,
                             left: qty_q, age: arrival_q};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cancel_q <= action_i;
      ident_q  <= order_ident_i;
      limit_q  <= limit_price_i;
      qty_q    <= share_count_i;
      sell_q   <= is_sell_i;
      market_q <= is_market_i;
    end
    rd_valid_q <= valid_q[scan_idx_q];
    rd_idx_q   <= scan_idx_q;
    if (take) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.fill_rest) begin
      fill_q <= fill_amt;
      qty_q  <= qty_q - fill_amt;
    end
    if (cmd_i.free_start) begin
      free_idx_q <= '0;
    end else if (cmd_i.free_step) begin
      free_idx_q <= free_idx_q + 1'b1;
    end
    if (out_free) begin
      olast_q <= 1'b1;
      osell_q <= 1'b0;
      oprice_q <= '0;
      oshares_q <= '0;
      oident_q <= ident_q;
      okind_q <= EV_REJECT;
      if (cmd_i.fill_rest) begin
        okind_q   <= EV_FILL;
        oident_q  <= best_q.ident;
        oprice_q  <= best_q.price;
        oshares_q <= fill_amt;
        osell_q   <= best_q.sell;
        olast_q   <= 1'b0;
      end else if (cmd_i.fill_inc) begin
        okind_q   <= EV_FILL;
        oprice_q  <= best_q.price;
        oshares_q <= fill_q;
        osell_q   <= sell_q;
        olast_q   <= (qty_q == '0);
      end else if (cmd_i.insert) begin
        okind_q   <= EV_ACK;
        oshares_q <= qty_q;
      end else if (cmd_i.emit_full) begin
        okind_q   <= EV_FULL;
      end else if (cmd_i.cancel_hit) begin
        okind_q   <= EV_CANCEL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      arrival_q  <= '0;
      issue_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      scan_idx_q <= '0;
      found_q    <= 1'b0;
      iter_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      rd_vld_q <= issue_q;
      if (cmd_i.scan_start) begin
        issue_q    <= 1'b1;
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else if (issue_q) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (scan_idx_q == LastIdx) begin
          issue_q <= 1'b0;
        end
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load) begin
        iter_q <= '0;
      end else if (cmd_i.fill_rest) begin
        iter_q <= iter_q + 1'b1;
      end
      if (cmd_i.fill_rest && (best_q.left == fill_amt)) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.cancel_hit) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.insert) begin
        valid_q[free_idx_q] <= 1'b1;
        arrival_q <= arrival_q + 1'b1;
      end
      if (cmd_i.fill_rest || cmd_i.fill_inc || cmd_i.emit_reject || cmd_i.insert ||
          cmd_i.emit_full || cmd_i.cancel_hit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.in_cancel   = action_i;
    sts_o.in_qty_zero = (share_count_i == '0);
    sts_o.scan_done   = rd_vld_q && (rd_idx_q == LastIdx);
    sts_o.found       = found_q;
    sts_o.is_cancel   = cancel_q;
    sts_o.market      = market_q;
    sts_o.qty_zero    = (qty_q == '0);
    sts_o.iter_last   = (iter_q == CW'(BOOK_DEPTH));
    sts_o.free_hit    = !valid_q[free_idx_q];
    sts_o.free_last   = (free_idx_q == LastIdx);
    sts_o.out_free    = out_free;
  end

  assign out_valid_o    = ov_q;
  assign event_kind_o   = okind_q;
  assign event_order_o  = oident_q;
  assign event_price_o  = oprice_q;
  assign event_shares_o = oshares_q;
  assign event_sell_o   = osell_q;
  assign last_event_o   = olast_q;

endmodule

@@ rtl/lobm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer: scan passes, fill emission, free slot search, insert, and the cancel, reject and full words.
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_FILL_R = 4'd3;
  localparam logic [3:0] S_FILL_I = 4'd4;
  localparam logic [3:0] S_END    = 4'd5;
  localparam logic [3:0] S_FREE   = 4'd6;
  localparam logic [3:0] S_INSERT = 4'd7;
  localparam logic [3:0] S_FULL   = 4'd8;
  localparam logic [3:0] S_CANCEL = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_cancel || !sts_i.in_qty_zero) begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_cancel) begin
          state_d = sts_i.found ? S_CANCEL : S_IDLE;
        end else begin
          state_d = sts_i.found ? S_FILL_R : S_END;
        end
      end
      S_FILL_R: begin
        if (sts_i.out_free) begin
          cmd_o.fill_rest = 1'b1;
          state_d = S_FILL_I;
        end
      end
      S_FILL_I: begin
        if (sts_i.out_free) begin
          cmd_o.fill_inc = 1'b1;
          if (sts_i.qty_zero) begin
            state_d = S_IDLE;
          end else if (sts_i.iter_last) begin
            state_d = S_END;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_END: begin
        if (sts_i.market) begin
          if (sts_i.out_free) begin
            cmd_o.emit_reject = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.free_start = 1'b1;
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        if (sts_i.free_hit) begin
          state_d = S_INSERT;
        end else if (sts_i.free_last) begin
          state_d = S_FULL;
        end else begin
          cmd_o.free_step = 1'b1;
        end
      end
      S_INSERT: begin
        if (sts_i.out_free) begin
          cmd_o.insert = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_full = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (sts_i.out_free) begin
          cmd_o.cancel_hit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/limit_order_book_matcher_top.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// A cancel scans the book for its ident; a hit frees the entry and emits a
// cancel word, a miss returns to idle with no output. A submit runs scan
// passes, each emitting two fill words for the best match (up to BOOK_DEPTH
// matches); any rest then gets a market reject or a free slot search and insert.
// One word in flight at a time; output stalls delay the work. Reset
// empties the book and zeroes the arrival counter; entry payloads undefined.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top import lobm_pkg::*; #(
  parameter int unsigned BOOK_DEPTH = DefBookDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [31:0]        order_ident_i,
  input  logic signed [31:0] limit_price_i,
  input  logic [31:0]        share_count_i,
  input  logic               is_sell_i,
  input  logic               is_market_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_kind_o,
  output logic [31:0]        event_order_o,
  output logic signed [31:0] event_price_o,
  output logic [31:0]        event_shares_o,
  output logic               event_sell_o,
  output logic               last_event_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the input handshake and steps through each word's work
  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // book memory, best-entry scan, fill math and the output register
  lobm_dp #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .order_ident_i  (order_ident_i),
    .limit_price_i  (limit_price_i),
    .share_count_i  (share_count_i),
    .is_sell_i      (is_sell_i),
    .is_market_i    (is_market_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .event_order_o  (event_order_o),
    .event_price_o  (event_price_o),
    .event_shares_o (event_shares_o),
    .event_sell_o   (event_sell_o),
    .last_event_o   (last_event_o)
  );

  // zero-quantity submit is dropped without leaving idle
  a_zero_qty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !action_i && (share_count_i == '0) |=> in_ready_o)
    else $error("zero-quantity submit left idle");

  // a fill always moves shares
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_FILL) |-> (event_shares_o != '0))
    else $error("fill with zero shares");

  // only fills carry a price
  a_price_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != EV_FILL) |-> (event_price_o == '0))
    else $error("non-fill word carries a price");

  // ack, reject, full and cancel always close the word's results
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != EV_FILL) |-> last_event_o)
    else $error("terminal event not marked last");

endmodule

@@ sim/lobm_checker.sv @@
// ----------------------------------------------------------------------------
// lobm_checker
// Watches both channels of the order book matcher, keeps a shadow book,
// predicts the events of every accepted word and compares them in order.
// ----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; #(
  parameter int unsigned BOOK_DEPTH = DefBookDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               action_i,
  input  logic [31:0]        order_ident_i,
  input  logic signed [31:0] limit_price_i,
  input  logic [31:0]        share_count_i,
  input  logic               is_sell_i,
  input  logic               is_market_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         event_kind_i,
  input  logic [31:0]        event_order_i,
  input  logic signed [31:0] event_price_i,
  input  logic [31:0]        event_shares_i,
  input  logic               event_sell_i,
  input  logic               last_event_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] order;
    logic [31:0] price;
    logic [31:0] shares;
    logic        sell;
    logic        last;
  } book_event_t;

  logic        bk_valid [BOOK_DEPTH];
  logic        bk_sell  [BOOK_DEPTH];
  logic [31:0] bk_price [BOOK_DEPTH];
  logic [31:0] bk_ident [BOOK_DEPTH];
  logic [31:0] bk_left  [BOOK_DEPTH];
  logic [31:0] bk_age   [BOOK_DEPTH];
  logic [31:0] arrivals;

  book_event_t expected_events[$];

  assign pending_o = expected_events.size();

  // better price first (low or high), then larger wrap distance = older
  function automatic bit ranks_ahead(int a, int b, bit low_wins);
    logic [31:0] pa, pb;
    pa = bk_price[a] ^ 32'h8000_0000;
    pb = bk_price[b] ^ 32'h8000_0000;
    if (pa != pb) return low_wins ? (pa < pb) : (pa > pb);
    return (arrivals - bk_age[a]) > (arrivals - bk_age[b]);
  endfunction

  function automatic void push_event(ev_kind_e k, logic [31:0] o, logic [31:0] p,
                                     logic [31:0] s, logic sd);
    book_event_t e;
    e.kind = k; e.order = o; e.price = p; e.shares = s; e.sell = sd; e.last = 1'b0;
    expected_events.push_back(e);
  endfunction

  function automatic void match_order(logic act, logic [31:0] id, logic [31:0] lim,
                                      logic [31:0] qty, logic sd, logic mkt);
    int n0, best, slot, hit;
    logic [31:0] fill, ep, lp;
    n0 = expected_events.size();
    if (act) begin
      hit = -1;
      for (int i = 0; i < BOOK_DEPTH; i++)
        if (bk_valid[i] && bk_ident[i] == id && (hit < 0 || ranks_ahead(i, hit, 1'b1)))
          hit = i;
      if (hit >= 0) begin
        bk_valid[hit] = 1'b0;
        push_event(EV_CANCEL, id, '0, '0, 1'b0);
      end
    end else if (qty != 0) begin
      for (int it = 0; it < BOOK_DEPTH && qty != 0; it++) begin
        best = -1;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
          if (!bk_valid[i] || bk_sell[i] == sd) continue;
          if (!mkt) begin
            ep = bk_price[i] ^ 32'h8000_0000;
            lp = lim ^ 32'h8000_0000;
            if (sd ? (ep < lp) : (ep > lp)) continue;
          end
          if (best < 0 || ranks_ahead(i, best, !sd)) best = i;
        end
        if (best < 0) break;
        fill = (bk_left[best] < qty) ? bk_left[best] : qty;
        push_event(EV_FILL, bk_ident[best], bk_price[best], fill, bk_sell[best]);
        push_event(EV_FILL, id, bk_price[best], fill, sd);
        bk_left[best] -= fill;
        qty -= fill;
        if (bk_left[best] == 0) bk_valid[best] = 1'b0;
      end
      if (qty != 0) begin
        if (mkt) push_event(EV_REJECT, id, '0, '0, 1'b0);
        else begin
          slot = -1;
          for (int i = 0; i < BOOK_DEPTH; i++)
            if (!bk_valid[i]) begin
              slot = i;
              break;
            end
          if (slot < 0) push_event(EV_FULL, id, '0, '0, 1'b0);
          else begin
            bk_valid[slot] = 1'b1; bk_sell[slot] = sd; bk_price[slot] = lim;
            bk_ident[slot] = id; bk_left[slot] = qty; bk_age[slot] = arrivals;
            arrivals++;
            push_event(EV_ACK, id, '0, qty, 1'b0);
          end
        end
      end
    end
    if (expected_events.size() > n0)
      expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    book_event_t e;
    if (!rst_ni) begin
      for (int i = 0; i < BOOK_DEPTH; i++) bk_valid[i] <= 1'b0;
      arrivals <= '0;
      fail_count_o <= 0;
      expected_events.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event word kind=%0d order=%0d", event_kind_i, event_order_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_events.pop_front();
          if (event_kind_i !== e.kind || event_order_i !== e.order ||
              event_price_i !== e.price || event_shares_i !== e.shares ||
              event_sell_i !== e.sell || last_event_i !== e.last) begin
            if (event_kind_i !== e.kind)
              $error("event_kind exp %0d got %0d", e.kind, event_kind_i);
            if (event_order_i !== e.order)
              $error("event_order exp %0d got %0d", e.order, event_order_i);
            if (event_price_i !== e.price)
              $error("event_price exp %0d got %0d", $signed(e.price), event_price_i);
            if (event_shares_i !== e.shares)
              $error("event_shares exp %0d got %0d", e.shares, event_shares_i);
            if (event_sell_i !== e.sell)
              $error("event_sell exp %0d got %0d", e.sell, event_sell_i);
            if (last_event_i !== e.last)
              $error("last_event exp %0d got %0d", e.last, last_event_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        match_order(action_i, order_ident_i, limit_price_i, share_count_i,
                    is_sell_i, is_market_i);
    end
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives order and cancel words into the order book matcher under random
// back-pressure; a checker beside the block predicts and compares events.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int unsigned Depth = DefBookDepth;
  localparam int MaxCycles = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               action_i = 1'b0;
  logic [31:0]        order_ident_i = '0;
  logic signed [31:0] limit_price_i = '0;
  logic [31:0]        share_count_i = '0;
  logic               is_sell_i = 1'b0;
  logic               is_market_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         event_kind_o;
  logic [31:0]        event_order_o;
  logic signed [31:0] event_price_o;
  logic [31:0]        event_shares_o;
  logic               event_sell_o;
  logic               last_event_o;
  int                 fail_count;
  int                 pending;

  // idle percentages per phase; phase 2 runs without gaps
  int send_idle_pct = 22;
  int recv_idle_pct = 58;
  int cycle_count = 0;
  // ids handed out so far, so cancels usually hit something
  logic [31:0] issued_ids[$];
  logic [31:0] next_ident = 32'd100;

  always #1 clk_i = ~clk_i;

  limit_order_book_matcher_top #(.BOOK_DEPTH(Depth)) uut (.*);

  lobm_checker #(.BOOK_DEPTH(Depth)) checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .order_ident_i,
    .limit_price_i, .share_count_i, .is_sell_i, .is_market_i,
    .out_valid_i(out_valid_o), .out_ready_i, .event_kind_i(event_kind_o),
    .event_order_i(event_order_o), .event_price_i(event_price_o),
    .event_shares_i(event_shares_o), .event_sell_i(event_sell_o),
    .last_event_i(last_event_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random, changed at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one word, hold it until accepted; sender gap first.
  // Valid drops only in a gap, so a word can follow back to back.
  task automatic send_word(logic act, logic [31:0] id, logic [31:0] px,
                           logic [31:0] qty, logic sd, logic mkt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act; order_ident_i <= id; limit_price_i <= px;
    share_count_i <= qty; is_sell_i <= sd; is_market_i <= mkt;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic submit_order(logic [31:0] px, logic [31:0] qty, logic sd, logic mkt);
    issued_ids.push_back(next_ident);
    send_word(1'b0, next_ident, px, qty, sd, mkt);
    next_ident++;
  endtask

  // mostly small prices near a center, shallow quantities so fills happen
  task automatic random_word();
    int r;
    logic [31:0] px, qty, id;
    r = $urandom_range(99);
    px = 32'(1000 + $urandom_range(10) - 5);
    qty = 32'($urandom_range(20));
    if ($urandom_range(19) == 0) px = $urandom;
    if ($urandom_range(19) == 0) qty = $urandom;
    if (r < 20 && issued_ids.size() > 0) begin
      id = issued_ids[$urandom_range(issued_ids.size() - 1)];
      send_word(1'b1, id, $urandom, $urandom, 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end else if (r < 25) begin
      send_word(1'b1, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end else if (r < 30) begin
      // duplicate id on purpose
      id = (issued_ids.size() > 0) ? issued_ids[$] : $urandom;
      send_word(1'b0, id, px, qty, 1'($urandom_range(1)), 1'b0);
    end else begin
      submit_order(px, qty, 1'($urandom_range(1)), ($urandom_range(9) == 0));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, zero quantity, book full, market, cancels
    submit_order(32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    submit_order(32'h8000_0000, 32'd5, 1'b0, 1'b0);
    submit_order(32'd0, 32'd0, 1'b0, 1'b0);
    submit_order(32'd0, 32'd7, 1'b0, 1'b1);         // market buy hits the top sell
    submit_order(32'd0, 32'd9, 1'b1, 1'b1);         // market sell on the 5-lot bid
    send_word(1'b1, 32'hdead_beef, '0, '0, 1'b0, 1'b0); // unknown cancel
    send_word(1'b1, 32'd100, $urandom, $urandom, 1'b1, 1'b1); // cancel resting sell
    for (int i = 0; i < Depth; i++) submit_order(32'(50 + (i % 3)), 32'd3, 1'b1, 1'b0);
    submit_order(32'd60, 32'd1, 1'b1, 1'b0);        // book full
    submit_order(32'd52, 32'd100, 1'b0, 1'b0);      // sweeps all, price then time priority
    send_word(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
    submit_order(32'd0, 32'd2, 1'b0, 1'b1);         // nothing left: reject

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 58; recv_idle_pct = 22; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int k = 0; k < 84; k++) random_word();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (4 * (Depth + 3) * Depth) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
